// ===== design/mx3i_pkg.sv =====
package mx3i_pkg;

  // entry format
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  // internal widths, all exact
  localparam int PROD_W     = 2 * WORD_BITS;
  localparam int COF_W      = 2 * WORD_BITS + 1;
  localparam int MAG_W      = 2 * WORD_BITS;
  localparam int DET_W      = 3 * WORD_BITS + 2;
  localparam int DMAG_W     = 3 * WORD_BITS + 1;
  localparam int NUM_SHIFT  = 2 * FRAC_BITS + 1;
  localparam int QUO_W      = WORD_BITS + 2;
  localparam int REM_A      = MAG_W + NUM_SHIFT;
  localparam int REM_B      = DMAG_W + QUO_W;
  localparam int REM_W      = ((REM_A > REM_B) ? REM_A : REM_B) + 1;
  localparam int THR_W      = 31;
  localparam int LANES      = 9;
  localparam int MAG_STAGES = 4;
  localparam int LATENCY    = QUO_W + 10;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [COF_W-1:0]     cof_t;
  typedef logic [DMAG_W-1:0]           dmag_t;

  typedef struct packed {
    word_t in_r0c0;
    word_t in_r0c1;
    word_t in_r0c2;
    word_t in_r1c0;
    word_t in_r1c1;
    word_t in_r1c2;
    word_t in_r2c0;
    word_t in_r2c1;
    word_t in_r2c2;
  } mat_in_t;

  typedef struct packed {
    word_t out_r0c0;
    word_t out_r0c1;
    word_t out_r0c2;
    word_t out_r1c0;
    word_t out_r1c1;
    word_t out_r1c2;
    word_t out_r2c0;
    word_t out_r2c1;
    word_t out_r2c2;
    logic  singular;
    logic  saturated;
  } mat_out_t;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } cof_mag_t;

  typedef struct packed {
    word_t entry;
    logic  sat;
  } lane_res_t;

  // matrix index of operand k (a, b, c, d) for cofactor lane; cof = a*b - c*d
  function automatic int cof_src(int lane, int k);
    int row, col, r1, r2, c1, c2;
    int idx [4];
    row = lane / 3;
    col = lane % 3;
    r1 = (row == 0) ? 1 : 0;
    r2 = (row == 2) ? 1 : 2;
    c1 = (col == 0) ? 1 : 0;
    c2 = (col == 2) ? 1 : 2;
    if (((row + col) % 2) == 0) begin
      idx[0] = r1 * 3 + c1;
      idx[1] = r2 * 3 + c2;
      idx[2] = r1 * 3 + c2;
      idx[3] = r2 * 3 + c1;
    end else begin
      idx[0] = r1 * 3 + c2;
      idx[1] = r2 * 3 + c1;
      idx[2] = r1 * 3 + c1;
      idx[3] = r2 * 3 + c2;
    end
    return idx[k];
  endfunction

endpackage

// ===== design/mx3i_cof_lane.sv =====
module mx3i_cof_lane (
  input  logic               clk_i,
  input  mx3i_pkg::word_t    a_i,
  input  mx3i_pkg::word_t    b_i,
  input  mx3i_pkg::word_t    c_i,
  input  mx3i_pkg::word_t    d_i,
  output mx3i_pkg::cof_t     cof_o,
  output mx3i_pkg::cof_mag_t mag_o
);
  import mx3i_pkg::*;

  logic signed [PROD_W-1:0] prod_ab, prod_cd;
  logic signed [PROD_W-1:0] prod_ab_q, prod_cd_q;
  cof_t                     cof_d, cof_q;
  logic [COF_W-1:0]         cof_abs;
  cof_mag_t                 mag_q [MAG_STAGES];

  // the two 2x2 minor products
  assign prod_ab = a_i * b_i;
  assign prod_cd = c_i * d_i;

  always_ff @(posedge clk_i) begin
    prod_ab_q <= prod_ab;
    prod_cd_q <= prod_cd;
  end

  // exact cofactor
  assign cof_d = COF_W'(prod_ab_q) - COF_W'(prod_cd_q);

  always_ff @(posedge clk_i) begin
    cof_q <= cof_d;
  end

  // magnitude and sign, held until the determinant is known
  assign cof_abs = cof_q[COF_W-1] ? (~cof_q + 1'b1) : cof_q;

  always_ff @(posedge clk_i) begin
    mag_q[0].neg <= cof_q[COF_W-1];
    mag_q[0].mag <= cof_abs[MAG_W-1:0];
    for (int k = 1; k < MAG_STAGES; k++) begin
      mag_q[k] <= mag_q[k-1];
    end
  end

  assign cof_o = cof_q;
  assign mag_o = mag_q[MAG_STAGES-1];

endmodule

// ===== design/mx3i_det.sv =====
module mx3i_det (
  input  logic            clk_i,
  input  mx3i_pkg::word_t row_i [3],
  input  mx3i_pkg::cof_t  cof_i [3],
  output mx3i_pkg::dmag_t dabs_o,
  output logic            dneg_o
);
  import mx3i_pkg::*;

  typedef logic signed [PROD_W:0] part_t;
  typedef logic signed [DET_W-1:0] dsum_t;

  part_t            lo_q [3];
  part_t            hi_q [3];
  dsum_t            term_q [3];
  dsum_t            det_q;
  logic [DET_W-1:0] det_abs;
  dmag_t            dabs_q;
  logic             dneg_q;

  // split each cofactor into a low unsigned word and a high signed part
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      lo_q[j] <= row_i[j] * $signed({1'b0, cof_i[j][WORD_BITS-1:0]});
      hi_q[j] <= row_i[j] * $signed(cof_i[j][COF_W-1:WORD_BITS]);
    end
  end

  // recombine partial products
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      term_q[j] <= (DET_W'(hi_q[j]) <<< WORD_BITS) + DET_W'(lo_q[j]);
    end
  end

  // expansion along row 0
  always_ff @(posedge clk_i) begin
    det_q <= term_q[0] + term_q[1] + term_q[2];
  end

  assign det_abs = det_q[DET_W-1] ? DET_W'(-det_q) : DET_W'(det_q);

  always_ff @(posedge clk_i) begin
    dneg_q <= det_q[DET_W-1];
    dabs_q <= det_abs[DMAG_W-1:0];
  end

  assign dabs_o = dabs_q;
  assign dneg_o = dneg_q;

endmodule

// ===== design/mx3i_div_lane.sv =====
module mx3i_div_lane (
  input  logic                clk_i,
  input  mx3i_pkg::cof_mag_t  mag_i,
  input  logic                dneg_i,
  input  mx3i_pkg::dmag_t     dabs_i,
  input  mx3i_pkg::dmag_t     dpipe_i [mx3i_pkg::QUO_W],
  output mx3i_pkg::lane_res_t res_o
);
  import mx3i_pkg::*;

  typedef logic [REM_W-1:0] rem_t;
  typedef logic [QUO_W-1:0] quo_t;

  rem_t        num;
  rem_t        rem_q [QUO_W];
  quo_t        quo_q [QUO_W+1];
  logic        big_q [QUO_W+1];
  logic        neg_q [QUO_W+1];
  logic [QUO_W:0] q_inc;
  quo_t        q_half, bound, q_clip;
  logic        clip;
  logic [QUO_W-1:0] q_signed;
  lane_res_t   res_q;

  // numerator and early overflow check
  assign num = rem_t'(mag_i.mag) << NUM_SHIFT;

  always_ff @(posedge clk_i) begin
    rem_q[0] <= num;
    quo_q[0] <= '0;
    big_q[0] <= num >= (rem_t'(dabs_i) << QUO_W);
    neg_q[0] <= mag_i.neg ^ dneg_i;
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    localparam int BIT = QUO_W - 1 - k;
    rem_t         sub_val;
    logic [REM_W:0] diff;
    logic         take;
    quo_t         quo_d;

    assign sub_val = rem_t'(dpipe_i[k]) << BIT;
    assign diff    = {1'b0, rem_q[k]} - {1'b0, sub_val};
    assign take    = ~diff[REM_W];

    always_comb begin
      quo_d      = quo_q[k];
      quo_d[BIT] = take;
    end

    always_ff @(posedge clk_i) begin
      quo_q[k+1] <= quo_d;
      big_q[k+1] <= big_q[k];
      neg_q[k+1] <= neg_q[k];
    end

    if (k < QUO_W - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        rem_q[k+1] <= take ? diff[REM_W-1:0] : rem_q[k];
      end
    end
  end

  // round half away from zero, clip, apply sign
  assign q_inc  = {1'b0, quo_q[QUO_W]} + 1'b1;
  assign q_half = q_inc[QUO_W:1];
  assign bound  = (quo_t'(1) << (WORD_BITS - 1)) - (neg_q[QUO_W] ? quo_t'(0) : quo_t'(1));
  assign clip   = big_q[QUO_W] || (q_half > bound);
  assign q_clip = clip ? bound : q_half;
  assign q_signed = neg_q[QUO_W] ? (~q_clip + 1'b1) : q_clip;

  always_ff @(posedge clk_i) begin
    res_q.entry <= q_signed[WORD_BITS-1:0];
    res_q.sat   <= clip;
  end

  assign res_o = res_q;

endmodule

// ===== design/matrix3x3_adjugate_inverse_unit.sv =====
// 3x3 matrix inverse by adjugate over signed Q16.16 entries. A new matrix is
// taken on every clock cycle (busy stays low) and its inverse comes out
// exactly 44 cycles after the transfer that took it in, one cycle per
// result on done_o, which the receiver must take as it appears. The latency
// is set by the nine parallel restoring divider lanes, one quotient bit per
// stage over 34 stages, behind ten stages of cofactor, determinant and
// merge logic. A determinant magnitude at or below singular_threshold
// (Q16.16) gives all-zero entries with singular set; entries out of range
// clip and set saturated. The threshold resets to 1 and may be rewritten
// only while no matrix is in flight.
module matrix3x3_adjugate_inverse_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  mx3i_pkg::mat_in_t           in_i,
  output logic                        done_o,
  output mx3i_pkg::mat_out_t          res_o,
  input  logic                        cfg_we_i,
  input  logic [mx3i_pkg::THR_W-1:0]  cfg_wdata_i
);
  import mx3i_pkg::*;

  logic [LATENCY-1:0] vld_q;
  logic [THR_W-1:0]   thr_q;
  word_t              mat_q  [9];
  word_t              row1_q [3];
  word_t              row2_q [3];
  cof_t               cof    [LANES];
  cof_mag_t           mag    [LANES];
  cof_t               cof_row [3];
  dmag_t              dabs;
  logic               dneg;
  dmag_t              dpipe_q [QUO_W];
  logic               sing_q  [QUO_W+2];
  logic               sing_d;
  lane_res_t          lane_res [LANES];
  word_t              ent [9];
  logic [LANES-1:0]   sat_bits;
  mat_out_t           res_d, res_q;

  // no back-pressure on the input side
  assign busy = 1'b0;

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LATENCY-2:0], start};
    end
  end

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_W'(1);
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // input capture
  always_ff @(posedge clk_i) begin
    mat_q[0] <= in_i.in_r0c0;
    mat_q[1] <= in_i.in_r0c1;
    mat_q[2] <= in_i.in_r0c2;
    mat_q[3] <= in_i.in_r1c0;
    mat_q[4] <= in_i.in_r1c1;
    mat_q[5] <= in_i.in_r1c2;
    mat_q[6] <= in_i.in_r2c0;
    mat_q[7] <= in_i.in_r2c1;
    mat_q[8] <= in_i.in_r2c2;
    for (int j = 0; j < 3; j++) begin
      row1_q[j] <= mat_q[j];
      row2_q[j] <= row1_q[j];
    end
  end

  // cofactor lanes
  for (genvar l = 0; l < LANES; l++) begin : g_cof
    mx3i_cof_lane u_cof (
      .clk_i (clk_i),
      .a_i   (mat_q[cof_src(l, 0)]),
      .b_i   (mat_q[cof_src(l, 1)]),
      .c_i   (mat_q[cof_src(l, 2)]),
      .d_i   (mat_q[cof_src(l, 3)]),
      .cof_o (cof[l]),
      .mag_o (mag[l])
    );
  end

  for (genvar j = 0; j < 3; j++) begin : g_row
    assign cof_row[j] = cof[j];
  end

  // determinant
  mx3i_det u_det (
    .clk_i  (clk_i),
    .row_i  (row2_q),
    .cof_i  (cof_row),
    .dabs_o (dabs),
    .dneg_o (dneg)
  );

  // singular test and shared divisor pipeline
  assign sing_d = REM_W'(dabs) <= (REM_W'(thr_q) << (2 * FRAC_BITS));

  always_ff @(posedge clk_i) begin
    dpipe_q[0] <= dabs;
    for (int k = 1; k < QUO_W; k++) begin
      dpipe_q[k] <= dpipe_q[k-1];
    end
    sing_q[0] <= sing_d;
    for (int k = 1; k < QUO_W + 2; k++) begin
      sing_q[k] <= sing_q[k-1];
    end
  end

  // divider lanes
  for (genvar l = 0; l < LANES; l++) begin : g_div
    mx3i_div_lane u_div (
      .clk_i   (clk_i),
      .mag_i   (mag[l]),
      .dneg_i  (dneg),
      .dabs_i  (dabs),
      .dpipe_i (dpipe_q),
      .res_o   (lane_res[l])
    );
    assign sat_bits[l] = lane_res[l].sat;
  end

  // merge: transpose the lanes, apply the singular case
  for (genvar o = 0; o < 9; o++) begin : g_ent
    assign ent[o] = sing_q[QUO_W+1] ? word_t'(0) : lane_res[(o % 3) * 3 + o / 3].entry;
  end

  always_comb begin
    res_d.out_r0c0  = ent[0];
    res_d.out_r0c1  = ent[1];
    res_d.out_r0c2  = ent[2];
    res_d.out_r1c0  = ent[3];
    res_d.out_r1c1  = ent[4];
    res_d.out_r1c2  = ent[5];
    res_d.out_r2c0  = ent[6];
    res_d.out_r2c1  = ent[7];
    res_d.out_r2c2  = ent[8];
    res_d.singular  = sing_q[QUO_W+1];
    res_d.saturated = ~sing_q[QUO_W+1] & (|sat_bits);
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o  = res_q;
  assign done_o = vld_q[LATENCY-1];

`ifndef NO_ASSERTIONS
  a_start_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##LATENCY done_o)
    else $error("transfer in gave no result");

  a_done_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, LATENCY))
    else $error("result without a transfer in");

  a_sing_nosat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.singular) |-> !res_o.saturated)
    else $error("singular result flagged saturated");

  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.singular) |->
      (res_o.out_r0c0 == 0 && res_o.out_r0c1 == 0 && res_o.out_r0c2 == 0 &&
       res_o.out_r1c0 == 0 && res_o.out_r1c1 == 0 && res_o.out_r1c2 == 0 &&
       res_o.out_r2c0 == 0 && res_o.out_r2c1 == 0 && res_o.out_r2c2 == 0))
    else $error("singular result with nonzero entries");
`endif

endmodule

// ===== bench/mx3i_checker.sv =====
module mx3i_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  logic                        busy,
  input  mx3i_pkg::mat_in_t           in_i,
  input  logic                        done_o,
  input  mx3i_pkg::mat_out_t          res_o,
  input  logic                        cfg_we_i,
  input  logic [mx3i_pkg::THR_W-1:0]  cfg_wdata_i,
  output int                          fail_count,
  output int                          pending
);
  import mx3i_pkg::*;

  localparam int WIDE = 256;
  typedef logic signed [WIDE-1:0] wide_t;

  logic [THR_W-1:0] threshold;
  mat_out_t inverse_q[$];

  // exact cofactor of the entry at (row, col)
  function automatic wide_t cofactor_of(wide_t m[9], int row, int col);
    int r1, r2, c1, c2;
    wide_t v;
    r1 = (row == 0) ? 1 : 0;
    r2 = (row == 2) ? 1 : 2;
    c1 = (col == 0) ? 1 : 0;
    c2 = (col == 2) ? 1 : 2;
    v = m[r1*3+c1] * m[r2*3+c2] - m[r1*3+c2] * m[r2*3+c1];
    if (((row + col) % 2) != 0) v = -v;
    return v;
  endfunction

  // adjugate over determinant, rounded half away from zero, clipped
  function automatic mat_out_t invert(mat_in_t a, logic [THR_W-1:0] thr);
    wide_t m[9];
    wide_t cof[9];
    wide_t det, dabs, lim, num, q, cmag, bound;
    mat_out_t r;
    word_t e[9];
    logic neg, sat;
    m[0] = wide_t'(a.in_r0c0); m[1] = wide_t'(a.in_r0c1); m[2] = wide_t'(a.in_r0c2);
    m[3] = wide_t'(a.in_r1c0); m[4] = wide_t'(a.in_r1c1); m[5] = wide_t'(a.in_r1c2);
    m[6] = wide_t'(a.in_r2c0); m[7] = wide_t'(a.in_r2c1); m[8] = wide_t'(a.in_r2c2);
    for (int i = 0; i < 9; i++) cof[i] = cofactor_of(m, i / 3, i % 3);
    det = m[0]*cof[0] + m[1]*cof[1] + m[2]*cof[2];
    dabs = (det < 0) ? -det : det;
    lim = wide_t'({1'b0, thr}) <<< (2*FRAC_BITS);
    r = '0;
    if (dabs <= lim) begin
      r.singular = 1'b1;
      return r;
    end
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        neg = (cof[j*3+i] < 0) != (det < 0);
        cmag = (cof[j*3+i] < 0) ? -cof[j*3+i] : cof[j*3+i];
        num = (cmag <<< (2*FRAC_BITS + 1)) + dabs;
        q = num / (dabs <<< 1);
        bound = (wide_t'(1) <<< (WORD_BITS-1)) - (neg ? 0 : 1);
        if (q > bound) begin
          q = bound;
          sat = 1'b1;
        end
        e[i*3+j] = neg ? word_t'(-q) : word_t'(q);
      end
    end
    r = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8], 1'b0, sat};
    return r;
  endfunction

  // field-wise comparison against the oldest expectation
  task automatic compare(mat_out_t exp_r, mat_out_t got);
    word_t ew[9], gw[9];
    {ew[0], ew[1], ew[2], ew[3], ew[4], ew[5], ew[6], ew[7], ew[8]} = exp_r[9*WORD_BITS+1:2];
    {gw[0], gw[1], gw[2], gw[3], gw[4], gw[5], gw[6], gw[7], gw[8]} = got[9*WORD_BITS+1:2];
    for (int k = 0; k < 9; k++) begin
      if (ew[k] !== gw[k]) begin
        $display("%0t entry r%0dc%0d: expected %0d, actual %0d",
                 $time, k / 3, k % 3, ew[k], gw[k]);
        fail_count++;
      end
    end
    if (exp_r.singular !== got.singular) begin
      $display("%0t singular: expected %b, actual %b", $time, exp_r.singular, got.singular);
      fail_count++;
    end
    if (exp_r.saturated !== got.saturated) begin
      $display("%0t saturated: expected %b, actual %b", $time, exp_r.saturated,
               got.saturated);
      fail_count++;
    end
  endtask

  // watch configuration, input and result transfers
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold <= THR_W'(1);
      fail_count = 0;
      inverse_q.delete();
    end else begin
      if (done_o === 1'b1) begin
        if (inverse_q.size() == 0) begin
          $display("%0t unexpected result: expected none, actual %h", $time, res_o);
          fail_count++;
        end else begin
          compare(inverse_q.pop_front(), res_o);
        end
      end
      if (start && !busy) inverse_q.push_back(invert(in_i, threshold));
      if (cfg_we_i) threshold <= cfg_wdata_i;
    end
  end

  assign pending = inverse_q.size();
endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  import mx3i_pkg::*;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  mat_in_t          in_i = '0;
  logic             done_o;
  mat_out_t         res_o;
  logic             cfg_we_i = 1'b0;
  logic [THR_W-1:0] cfg_wdata_i = '0;
  int               fail_count;
  int               pending;
  int               idle_pct;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  matrix3x3_adjugate_inverse_unit dut (.*);

  mx3i_checker u_checker (.*);

  // random entry: mostly small magnitudes so inverses stay meaningful
  function automatic word_t rand_entry();
    case ($urandom_range(0, 9))
      0:       return word_t'($urandom);
      1:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      2, 3:    return word_t'($signed($urandom_range(0, 65535)) - 32768);
      default: return word_t'($signed($urandom_range(0, 32'h7ffff)) - 32'sh40000);
    endcase
  endfunction

  function automatic mat_in_t rand_matrix();
    mat_in_t mx;
    word_t w[9];
    for (int k = 0; k < 9; k++) w[k] = rand_entry();
    // some near-singular matrices: row 2 copies row 0, maybe nudged
    if ($urandom_range(0, 7) == 0) begin
      w[6] = w[0];
      w[7] = w[1];
      w[8] = w[2] + word_t'($urandom_range(0, 3));
    end
    mx = {w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7], w[8]};
    return mx;
  endfunction

  // one input transfer with random sender idling
  task automatic send(mat_in_t mx);
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    in_i  <= mx;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic set_threshold(logic [THR_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic mat_in_t diag(word_t a, word_t b, word_t c);
    mat_in_t mx;
    mx = '0;
    mx.in_r0c0 = a;
    mx.in_r1c1 = b;
    mx.in_r2c2 = c;
    return mx;
  endfunction

  initial begin
    logic [THR_W-1:0] thr_set[4];
    mat_in_t mx;
    thr_set = '{31'h0, 31'h7fffffff, 31'h10000, 31'h1};
    idle_pct = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: identity, zero, extremes, saturation, singular edge
    send(diag(32'sh10000, 32'sh10000, 32'sh10000));
    send('0);
    send({9{32'sh7fffffff}});
    send({9{32'sh80000000}});
    send({9{32'shffffffff}});
    send(diag(32'sh1, 32'sh1, 32'sh1));
    send(diag(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff));
    send(diag(32'sh80000000, 32'sh80000000, 32'sh80000000));
    send(diag(32'sh20000, -32'sh30000, 32'sh40000));
    send(diag(32'sh10000, 32'sh10000, 32'sh1));
    send(diag(32'sh100, 32'sh100, 32'sh100));
    send(diag(32'sh3, 32'sh10000, 32'sh10000));
    send({32'sh10000, 32'sh20000, 32'sh30000, 32'sh40000, 32'sh50000,
          32'sh60000, 32'sh70000, 32'sh80000, 32'sh90001});
    send({32'sh55555555, 32'shaaaaaaaa, 32'sh0, 32'sh0, 32'sh55555555,
          32'shaaaaaaaa, 32'shaaaaaaaa, 32'sh0, 32'sh55555555});
    drain();

    // random phases, each setting the threshold and idling mix at its start
    for (int ph = 0; ph < 8; ph++) begin
      set_threshold((ph < 4) ? thr_set[ph] : 31'($urandom_range(0, 32'h3ffff)));
      idle_pct = (ph % 4 == 1) ? 63 : (ph % 4 == 3) ? 6 : 0;
      for (int n = 0; n < 85; n++) begin
        mx = rand_matrix();
        send(mx);
        // sender waits for everything outstanding once
        if (ph == 2 && n == 40) begin
          start <= 1'b0;
          @(posedge clk_i);
          while (pending != 0) @(posedge clk_i);
        end
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("matrix3x3_adjugate_inverse_unit regression: pass");
    end else begin
      $display("matrix3x3_adjugate_inverse_unit regression: fail");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("matrix3x3_adjugate_inverse_unit regression: fail");
    $finish;
  end
endmodule

// ===== matrix3x3_adjugate_inverse_unit.f =====
design/mx3i_pkg.sv
design/mx3i_cof_lane.sv
design/mx3i_det.sv
design/mx3i_div_lane.sv
design/matrix3x3_adjugate_inverse_unit.sv
bench/mx3i_checker.sv
bench/tb_top.sv
